FILE: hw/rtl/apw_pkg.sv
// ----------------------------------------------------------------------------
// apw_pkg
// Shared types and constants of the ARGB pixel writer: frame memory size,
// configuration register indexes, status codes and the queued job word.
// ----------------------------------------------------------------------------
package apw_pkg;

    localparam int FRAME_WORDS = 65536;
    localparam int ADDR_W      = $clog2(FRAME_WORDS);
    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SURFACE_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_SURFACE_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_CLIP_ENABLE    = 3'd2;
    localparam t_cfg_idx CFG_CLIP_LEFT      = 3'd3;
    localparam t_cfg_idx CFG_CLIP_TOP       = 3'd4;
    localparam t_cfg_idx CFG_CLIP_RIGHT     = 3'd5;
    localparam t_cfg_idx CFG_CLIP_BOTTOM    = 3'd6;
    localparam t_cfg_idx CFG_ROW_PITCH      = 3'd7;

    typedef logic [1:0] t_status;

    localparam t_status ST_WRITTEN        = 2'd0;
    localparam t_status ST_OUTSIDE_SURFACE = 2'd1;
    localparam t_status ST_OUTSIDE_CLIP   = 2'd2;
    localparam t_status ST_BEYOND_MEMORY  = 2'd3;

    typedef struct packed {
        t_status           status;
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       colour;
    } t_job;

endpackage

FILE: hw/rtl/apw_front.sv
// ----------------------------------------------------------------------------
// apw_front
// Holds the configuration registers, accepts pixel words, checks them against
// the surface and the clip rectangle and forms the word address from the
// registered row product before handing a classified job to the queue.
// ----------------------------------------------------------------------------
module apw_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  apw_pkg::t_cfg_idx              i_cfg_index,
    input  logic [apw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic signed [15:0]             i_pos_x,
    input  logic signed [15:0]             i_pos_y,
    input  logic [31:0]                    i_colour,
    output logic                           o_push,
    output apw_pkg::t_job                  o_job,
    input  logic                           i_full
);

    logic [14:0]        r_surface_width;
    logic [14:0]        r_surface_height;
    logic               r_clip_enable;
    logic signed [15:0] r_clip_left;
    logic signed [15:0] r_clip_top;
    logic signed [15:0] r_clip_right;
    logic signed [15:0] r_clip_bottom;
    logic [14:0]        r_row_pitch;

    logic               r_s1_valid;
    apw_pkg::t_status   r_s1_status;
    logic               r_s1_mode;
    logic [31:0]        r_s1_colour;
    logic [14:0]        r_s1_x;
    logic [29:0]        r_s1_prod;

    logic               w_accept;
    logic               w_out_surf;
    logic               w_out_clip;
    apw_pkg::t_status   n_s1_status;
    logic [30:0]        w_addr;
    logic               w_beyond;

    always_comb begin
        w_accept   = i_in_valid && !o_in_stall;
        w_out_surf = i_pos_x[15] || i_pos_y[15] ||
                     (i_pos_x[14:0] >= r_surface_width) ||
                     (i_pos_y[14:0] >= r_surface_height);
        w_out_clip = r_clip_enable &&
                     ((i_pos_x < r_clip_left) || (i_pos_y < r_clip_top) ||
                      (i_pos_x >= r_clip_right) || (i_pos_y >= r_clip_bottom));
        if (w_out_surf) begin
            n_s1_status = apw_pkg::ST_OUTSIDE_SURFACE;
        end else if (w_out_clip) begin
            n_s1_status = apw_pkg::ST_OUTSIDE_CLIP;
        end else begin
            n_s1_status = apw_pkg::ST_WRITTEN;
        end
    end

    assign o_in_stall = r_s1_valid && i_full;

    always_comb begin
        w_addr   = 31'(r_s1_prod) + 31'(r_s1_x);
        w_beyond = w_addr >= 31'(apw_pkg::FRAME_WORDS);
        o_push   = r_s1_valid && !i_full;
        o_job.status = (r_s1_status == apw_pkg::ST_WRITTEN && w_beyond) ?
                       apw_pkg::ST_BEYOND_MEMORY : r_s1_status;
        o_job.mode   = r_s1_mode;
        o_job.addr   = w_addr[apw_pkg::ADDR_W-1:0];
        o_job.colour = r_s1_colour;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_width  <= '0;
            r_surface_height <= '0;
            r_clip_enable    <= 1'b0;
            r_clip_left      <= '0;
            r_clip_top       <= '0;
            r_clip_right     <= '0;
            r_clip_bottom    <= '0;
            r_row_pitch      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                apw_pkg::CFG_SURFACE_WIDTH:  r_surface_width  <= i_cfg_data[14:0];
                apw_pkg::CFG_SURFACE_HEIGHT: r_surface_height <= i_cfg_data[14:0];
                apw_pkg::CFG_CLIP_ENABLE:    r_clip_enable    <= i_cfg_data[0];
                apw_pkg::CFG_CLIP_LEFT:      r_clip_left      <= i_cfg_data;
                apw_pkg::CFG_CLIP_TOP:       r_clip_top       <= i_cfg_data;
                apw_pkg::CFG_CLIP_RIGHT:     r_clip_right     <= i_cfg_data;
                apw_pkg::CFG_CLIP_BOTTOM:    r_clip_bottom    <= i_cfg_data;
                apw_pkg::CFG_ROW_PITCH:      r_row_pitch      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= n_s1_status;
            r_s1_mode   <= i_mode;
            r_s1_colour <= i_colour;
            r_s1_x      <= i_pos_x[14:0];
            r_s1_prod   <= 30'(i_pos_y[14:0]) * 30'(r_row_pitch);
        end
    end

endmodule

FILE: hw/rtl/apw_queue.sv
// ----------------------------------------------------------------------------
// apw_queue
// Short first-in first-out queue of classified jobs between the front and the
// back, so that each side may stall without holding up the other.
// ----------------------------------------------------------------------------
module apw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  apw_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output apw_pkg::t_job o_head,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(apw_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(apw_pkg::QUEUE_DEPTH + 1);

    apw_pkg::t_job r_entry [apw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(apw_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(apw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(apw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from an empty queue");

endmodule

FILE: hw/rtl/apw_back.sv
// ----------------------------------------------------------------------------
// apw_back
// Takes classified jobs from the queue, reads the frame memory for a writable
// pixel, blends or overwrites it, writes it back and presents the result word.
// ----------------------------------------------------------------------------
module apw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  apw_pkg::t_job    i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output apw_pkg::t_status o_status,
    output logic [15:0]      o_word_address,
    output logic [31:0]      o_old_pixel,
    output logic [31:0]      o_new_pixel
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_FIN
    } t_state;

    t_state           r_state;
    apw_pkg::t_job    r_job;
    logic [31:0]      r_mem [apw_pkg::FRAME_WORDS];
    logic [31:0]      r_rd_data;
    logic [31:0]      r_old;
    logic [15:0]      r_sum [4];

    logic             r_out_valid;
    apw_pkg::t_status r_out_status;
    logic [15:0]      r_out_word;
    logic [31:0]      r_out_old;
    logic [31:0]      r_out_new;

    logic             w_out_free;
    logic             w_we;
    logic             w_load;
    logic [7:0]       w_alpha;
    logic [15:0]      n_sum [4];
    logic [7:0]       w_quot [4];
    logic [31:0]      w_new;

    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        o_pop      = (r_state == S_IDLE) && !i_empty && w_out_free;
        w_we       = (r_state == S_FIN) && w_out_free;
        w_load     = (o_pop && i_head.status != apw_pkg::ST_WRITTEN) || w_we;
        w_alpha    = r_job.colour[31:24];
        for (int c = 0; c < 4; c++) begin
            n_sum[c] = 16'(r_job.colour[8*c +: 8]) * 16'(w_alpha) +
                       16'(r_rd_data[8*c +: 8]) * 16'(8'd255 - w_alpha);
            w_quot[c] = 8'((17'(r_sum[c]) + 17'd1 + 17'(r_sum[c][15:8])) >> 8);
        end
        w_new = r_job.mode ? {w_quot[3], w_quot[2], w_quot[1], w_quot[0]} : r_job.colour;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_job.addr] <= w_new;
        end
        r_rd_data <= r_mem[i_head.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_job <= i_head;
                        if (i_head.status != apw_pkg::ST_WRITTEN) begin
                            r_out_status <= i_head.status;
                            r_out_word   <= '0;
                            r_out_old    <= '0;
                            r_out_new    <= '0;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_old   <= r_rd_data;
                    r_sum   <= n_sum;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_status <= apw_pkg::ST_WRITTEN;
                        r_out_word   <= 16'(r_job.addr);
                        r_out_old    <= r_old;
                        r_out_new    <= w_new;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_word_address = r_out_word;
    assign o_old_pixel    = r_out_old;
    assign o_new_pixel    = r_out_new;

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != apw_pkg::ST_WRITTEN) |->
        (o_word_address == '0 && o_old_pixel == '0 && o_new_pixel == '0))
        else $error("dropped pixel reported with non-zero fields");

    a_rd_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_FIN))
        else $error("memory read not followed by the write step");

    a_write_job_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.status == apw_pkg::ST_WRITTEN) |=> (r_state == S_RD))
        else $error("writable pixel taken without a memory read");

endmodule

FILE: hw/rtl/argb_pixel_writer_with_clip_blend_top.sv
// ----------------------------------------------------------------------------
// argb_pixel_writer_with_clip_blend_top
// A dropped pixel passes the input stage, the queue and the output register;
// a written one also passes the read and blend steps before its output word.
// Throughput: dropped pixels one per cycle unless a stall holds them; a written
// pixel holds the single frame memory port pair for its read, blend and write.
// Reset clears the configuration registers, queue and state; the frame memory
// is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
module argb_pixel_writer_with_clip_blend_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [apw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic signed [15:0]             i_pos_x,
    input  logic signed [15:0]             i_pos_y,
    input  logic [31:0]                    i_colour,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_status,
    output logic [15:0]                    o_word_address,
    output logic [31:0]                    o_old_pixel,
    output logic [31:0]                    o_new_pixel
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    apw_pkg::t_job w_job;
    apw_pkg::t_job w_head;

    apw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_colour    (i_colour),
        .o_push      (w_push),
        .o_job       (w_job),
        .i_full      (w_full)
    );

    apw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    apw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_word_address (o_word_address),
        .o_old_pixel    (o_old_pixel),
        .o_new_pixel    (o_new_pixel)
    );

endmodule

FILE: verif/tb_argb_pixel_writer_with_clip_blend_top.sv
// ----------------------------------------------------------------------------
// tb_argb_pixel_writer_with_clip_blend_top
// Self-checking bench for the ARGB pixel writer. A queue of pixel requests is
// filled per configuration phase and fed to the block by a clocked driver.
// A clocked monitor runs a shadow frame memory with the same bounds, clip and
// blend rules, and compares each result word field by field in order.
// Idling on both sides, a long output hold-off and drain points between phases
// exercise the queue, the read-modify-write path and repeated addresses.
// ----------------------------------------------------------------------------
module tb_argb_pixel_writer_with_clip_blend_top;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 10;

    typedef struct {
        logic               mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        colour;
    } t_pixel_req;

    typedef struct {
        apw_pkg::t_status status;
        logic [15:0]      word_address;
        logic [31:0]      old_pixel;
        logic [31:0]      new_pixel;
        bit               old_known;
    } t_pixel_result;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [apw_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [apw_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    logic                           i_mode      = 1'b0;
    logic signed [15:0]             i_pos_x     = '0;
    logic signed [15:0]             i_pos_y     = '0;
    logic [31:0]                    i_colour    = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [1:0]                     o_status;
    logic [15:0]                    o_word_address;
    logic [31:0]                    o_old_pixel;
    logic [31:0]                    o_new_pixel;

    int  cfg_width;
    int  cfg_height;
    int  cfg_pitch;
    bit  cfg_clip_en;
    int  cfg_clip_left;
    int  cfg_clip_top;
    int  cfg_clip_right;
    int  cfg_clip_bottom;

    logic [31:0] frame_shadow    [apw_pkg::FRAME_WORDS];
    bit          shadow_written  [apw_pkg::FRAME_WORDS];
    bit          planned_written [apw_pkg::FRAME_WORDS];

    t_pixel_req    pending_pixels[$];
    t_pixel_result expected_results[$];
    t_pixel_req    next_pixel;
    t_pixel_result expected_word;

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int quiet_cycles;
    int fault_count;
    int words_checked;

    argb_pixel_writer_with_clip_blend_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_colour       (i_colour),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_word_address (o_word_address),
        .o_old_pixel    (o_old_pixel),
        .o_new_pixel    (o_new_pixel)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic apw_pkg::t_status locate_pixel(logic signed [15:0] x,
                                                      logic signed [15:0] y,
                                                      output longint addr);
        int sx;
        int sy;
        sx   = x;
        sy   = y;
        addr = 0;
        if (sx < 0 || sy < 0 || sx >= cfg_width || sy >= cfg_height) begin
            return apw_pkg::ST_OUTSIDE_SURFACE;
        end
        if (cfg_clip_en && (sx < cfg_clip_left || sy < cfg_clip_top ||
                            sx >= cfg_clip_right || sy >= cfg_clip_bottom)) begin
            return apw_pkg::ST_OUTSIDE_CLIP;
        end
        addr = longint'(sy) * cfg_pitch + sx;
        if (addr >= apw_pkg::FRAME_WORDS) begin
            return apw_pkg::ST_BEYOND_MEMORY;
        end
        return apw_pkg::ST_WRITTEN;
    endfunction

    function automatic t_pixel_result apply_pixel_write(t_pixel_req px);
        t_pixel_result res;
        longint        addr;
        logic [31:0]   oldp;
        logic [31:0]   newp;
        int            alpha;
        res.status       = locate_pixel(px.pos_x, px.pos_y, addr);
        res.word_address = '0;
        res.old_pixel    = '0;
        res.new_pixel    = '0;
        res.old_known    = 1'b1;
        if (res.status == apw_pkg::ST_WRITTEN) begin
            res.old_known = shadow_written[addr];
            oldp  = res.old_known ? frame_shadow[addr] : 32'd0;
            alpha = px.colour[31:24];
            if (px.mode) begin
                for (int c = 0; c < 4; c++) begin
                    newp[c*8 +: 8] = 8'((int'(px.colour[c*8 +: 8]) * alpha +
                                         int'(oldp[c*8 +: 8]) * (255 - alpha)) / 255);
                end
            end else begin
                newp = px.colour;
            end
            frame_shadow[addr]   = newp;
            shadow_written[addr] = 1'b1;
            res.word_address     = addr[15:0];
            res.old_pixel        = oldp;
            res.new_pixel        = newp;
        end
        return res;
    endfunction

    function automatic void queue_pixel(logic mode, logic signed [15:0] x,
                                        logic signed [15:0] y, logic [31:0] colour);
        t_pixel_req px;
        longint     addr;
        px.mode   = mode;
        px.pos_x  = x;
        px.pos_y  = y;
        px.colour = colour;
        if (locate_pixel(x, y, addr) == apw_pkg::ST_WRITTEN) begin
            // Blending over a word that has never been written would read undefined memory.
            if (!planned_written[addr]) begin
                px.mode = 1'b0;
            end
            planned_written[addr] = 1'b1;
        end
        pending_pixels.push_back(px);
    endfunction

    task automatic queue_random_pixels(int count, int org_x, int span_x, int org_y, int span_y);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        colour;
        int                 pick;
        x = 16'(org_x);
        y = 16'(org_y);
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else if (pick >= 30) begin
                x = 16'(org_x + $urandom_range(span_x - 1));
                y = 16'(org_y + $urandom_range(span_y - 1));
            end
            colour = $urandom;
            case ($urandom_range(9))
                0: begin
                    colour[31:24] = 8'h00;
                end
                1: begin
                    colour[31:24] = 8'hFF;
                end
                default: begin
                end
            endcase
            queue_pixel(1'($urandom_range(1)), x, y, colour);
        end
    endtask

    task automatic write_reg(apw_pkg::t_cfg_idx index, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (index)
            apw_pkg::CFG_SURFACE_WIDTH: begin
                cfg_width = data[14:0];
            end
            apw_pkg::CFG_SURFACE_HEIGHT: begin
                cfg_height = data[14:0];
            end
            apw_pkg::CFG_CLIP_ENABLE: begin
                cfg_clip_en = data[0];
            end
            apw_pkg::CFG_CLIP_LEFT: begin
                cfg_clip_left = $signed(data);
            end
            apw_pkg::CFG_CLIP_TOP: begin
                cfg_clip_top = $signed(data);
            end
            apw_pkg::CFG_CLIP_RIGHT: begin
                cfg_clip_right = $signed(data);
            end
            apw_pkg::CFG_CLIP_BOTTOM: begin
                cfg_clip_bottom = $signed(data);
            end
            apw_pkg::CFG_ROW_PITCH: begin
                cfg_pitch = data[14:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_surface(int width, int height, int pitch);
        write_reg(apw_pkg::CFG_SURFACE_WIDTH, 16'(width));
        write_reg(apw_pkg::CFG_SURFACE_HEIGHT, 16'(height));
        write_reg(apw_pkg::CFG_ROW_PITCH, 16'(pitch));
    endtask

    task automatic set_clip(bit enable, int left, int top, int right, int bottom);
        write_reg(apw_pkg::CFG_CLIP_ENABLE, {15'd0, enable});
        write_reg(apw_pkg::CFG_CLIP_LEFT, 16'(left));
        write_reg(apw_pkg::CFG_CLIP_TOP, 16'(top));
        write_reg(apw_pkg::CFG_CLIP_RIGHT, 16'(right));
        write_reg(apw_pkg::CFG_CLIP_BOTTOM, 16'(bottom));
    endtask

    task automatic wait_until_idle();
        while (pending_pixels.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_fault(string msg);
        fault_count++;
        $display("MISMATCH at word %0d: %s", words_checked, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_fault($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_pixel = pending_pixels.pop_front();
                i_in_valid <= 1'b1;
                i_mode     <= next_pixel.mode;
                i_pos_x    <= next_pixel.pos_x;
                i_pos_y    <= next_pixel.pos_y;
                i_colour   <= next_pixel.colour;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_OFF_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                words_checked++;
                if (expected_results.size() == 0) begin
                    report_fault($sformatf("word with status %0d arrived, none expected",
                                           o_status));
                end else begin
                    expected_word = expected_results.pop_front();
                    compare_field("status", 32'(o_status), 32'(expected_word.status));
                    compare_field("word_address", 32'(o_word_address),
                                  32'(expected_word.word_address));
                    if (expected_word.old_known) begin
                        compare_field("old_pixel", o_old_pixel, expected_word.old_pixel);
                    end
                    compare_field("new_pixel", o_new_pixel, expected_word.new_pixel);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(
                    apply_pixel_write(t_pixel_req'{i_mode, i_pos_x, i_pos_y, i_colour}));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at their reset values: the surface is empty.
        queue_pixel(1'b0, 16'sd0, 16'sd0, 32'h12345678);
        queue_pixel(1'b1, -16'sd1, -16'sd1, 32'hFFFFFFFF);
        queue_random_pixels(20, 0, 8, 0, 8);

        wait_until_idle();
        set_surface(0, 32767, 32767);
        set_clip(1'b1, -32768, -32768, 32767, 32767);
        sender_idle_pct = 56;
        queue_random_pixels(20, 0, 4, 0, 4);

        // Small surface, a disabled clip rectangle that would reject everything.
        // Bit 15 of the width write lies beyond the register and is ignored.
        wait_until_idle();
        set_surface(32784, 16, 16);
        set_clip(1'b0, 100, 100, -100, -100);
        sender_idle_pct = 0;
        queue_pixel(1'b0, 16'sd0, 16'sd0, 32'hFFFFFFFF);
        queue_pixel(1'b0, 16'sd15, 16'sd15, 32'h00000000);
        queue_pixel(1'b0, 16'sd16, 16'sd0, 32'hA5A5A5A5);
        queue_pixel(1'b1, 16'sd0, 16'sd16, 32'h5A5A5A5A);
        queue_pixel(1'b0, -16'sd32768, 16'sd32767, 32'h01020304);
        queue_pixel(1'b1, 16'sd32767, -16'sd32768, 32'hFFFFFFFF);
        queue_pixel(1'b1, 16'sd0, 16'sd0, 32'h00123456);
        queue_pixel(1'b1, 16'sd0, 16'sd0, 32'hFF89ABCD);
        queue_pixel(1'b1, 16'sd0, 16'sd0, 32'h80FF7F01);
        queue_pixel(1'b0, 16'sd15, 16'sd15, 32'h7F102030);
        queue_pixel(1'b1, 16'sd15, 16'sd15, 32'h7FEFDFCF);
        queue_random_pixels(250, 0, 18, 0, 18);
        hold_requests++;

        // Clip rectangle inside the surface, edges probed on both sides.
        wait_until_idle();
        set_surface(16, 16, 16);
        set_clip(1'b1, 2, 3, 10, 12);
        sender_idle_pct = 56;
        queue_pixel(1'b0, 16'sd1, 16'sd5, 32'h11111111);
        queue_pixel(1'b0, 16'sd2, 16'sd3, 32'h22222222);
        queue_pixel(1'b1, 16'sd9, 16'sd11, 32'h33333333);
        queue_pixel(1'b0, 16'sd10, 16'sd5, 32'h44444444);
        queue_pixel(1'b0, 16'sd5, 16'sd12, 32'h55555555);
        queue_pixel(1'b0, 16'sd5, 16'sd2, 32'h66666666);
        queue_pixel(1'b0, 16'sd20, 16'sd5, 32'h77777777);
        queue_random_pixels(250, 0, 18, 0, 18);

        // Largest surface and pitch: addresses run past the end of the memory.
        wait_until_idle();
        set_surface(32767, 32767, 32767);
        set_clip(1'b0, -32768, -32768, 32767, 32767);
        sender_idle_pct    = 0;
        receiver_stall_pct = 56;
        queue_pixel(1'b0, 16'sd1, 16'sd2, 32'hDEADBEEF);
        queue_pixel(1'b0, 16'sd2, 16'sd2, 32'hCAFEF00D);
        queue_pixel(1'b1, 16'sd32766, 16'sd32766, 32'h80808080);
        queue_pixel(1'b1, 16'sd1, 16'sd2, 32'hC0402010);
        queue_random_pixels(250, 0, 40, 0, 4);

        wait_until_idle();
        set_surface(300, 300, 200);
        set_clip(1'b1, -32768, -32768, 32767, 32767);
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
        queue_random_pixels(300, 280, 24, 280, 24);

        // Clip rectangle with its edges crossed: nothing inside the surface survives.
        wait_until_idle();
        set_surface(64, 64, 64);
        set_clip(1'b1, 32767, 32767, -32768, -32768);
        sender_idle_pct    = 56;
        receiver_stall_pct = 0;
        queue_random_pixels(200, 0, 70, 0, 70);

        // Zero pitch folds every row onto the first one.
        wait_until_idle();
        set_surface(64, 32767, 0);
        set_clip(1'b0, 40, 40, 41, 41);
        sender_idle_pct    = 0;
        receiver_stall_pct = 56;
        queue_random_pixels(250, 0, 70, 32740, 28);

        wait_until_idle();
        set_surface(16, 16, 16);
        set_clip(1'b1, 0, 0, 16, 16);
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
        queue_random_pixels(150, 0, 17, 0, 17);

        wait_until_idle();
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
